// ===== rtl/core/ckpm_pkg.sv =====
package ckpm_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned DistW = 18;
  localparam int unsigned ModeW = 2;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // register map, byte address = 4 * index
  localparam logic [RegIdxW-1:0] REG_KEY_RED     = 3'd0;
  localparam logic [RegIdxW-1:0] REG_KEY_GREEN   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_KEY_BLUE    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DIST_MODE   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_MATCH_THRESH = 3'd4;

  localparam logic [ModeW-1:0] MODE_SAD = 2'd0;
  localparam logic [ModeW-1:0] MODE_SSD = 2'd1;
  localparam logic [ModeW-1:0] MODE_MAX = 2'd2;

  localparam logic [ChanW-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [ChanW-1:0] ALPHA_CLEAR  = 8'd0;

  localparam logic [ChanW-1:0] KEY_RED_RST   = 8'd0;
  localparam logic [ChanW-1:0] KEY_GREEN_RST = 8'd0;
  localparam logic [ChanW-1:0] KEY_BLUE_RST  = 8'd255;
  localparam logic [ModeW-1:0] DIST_MODE_RST = MODE_SAD;
  localparam logic [DistW-1:0] THRESH_RST    = 18'd10;

  typedef struct packed {
    logic [ChanW-1:0] fg_red;
    logic [ChanW-1:0] fg_green;
    logic [ChanW-1:0] fg_blue;
    logic [ChanW-1:0] bg_red;
    logic [ChanW-1:0] bg_green;
    logic [ChanW-1:0] bg_blue;
    logic [ChanW-1:0] alpha_in;
  } ckpm_pixel_t;

  typedef struct packed {
    logic             key_match;
    logic [DistW-1:0] color_distance;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] alpha_new;
    logic [ChanW-1:0] alpha_updated;
  } ckpm_result_t;

endpackage

// ===== rtl/core/ckpm_if.sv =====
interface ckpm_pixel_if;
  logic                 valid;
  logic                 ready;
  ckpm_pkg::ckpm_pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ckpm_result_if;
  logic                  valid;
  logic                  ready;
  ckpm_pkg::ckpm_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/chroma_key_pixel_matcher.sv =====
// Channel | Dir | Payload                                    | Handshake
// pixel   | in  | fg rgb, bg rgb, alpha_in                   | valid/ready
// result  | out | match, distance, composite rgb, two alphas  | valid/ready
// apb     | in  | key rgb, distance mode, threshold          | psel/penable, pready=1
//
// Two register stages: input register, then result register.
// One request per cycle sustained while result is ready; distance math sits between the two stages.
// rst (sync, high) empties both stages and restores register defaults.
// A stall on result backs up into pixel.ready only when both stages hold data.
module chroma_key_pixel_matcher (
  input  logic                          clk,
  input  logic                          rst,
  ckpm_pixel_if.sink                    pixel,
  ckpm_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ckpm_pkg::ApbAddrW-1:0] paddr,
  input  logic [ckpm_pkg::ApbDataW-1:0] pwdata,
  output logic [ckpm_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import ckpm_pkg::*;

  logic [ChanW-1:0] key_red;
  logic [ChanW-1:0] key_green;
  logic [ChanW-1:0] key_blue;
  logic [ModeW-1:0] distance_mode;
  logic [DistW-1:0] match_threshold;

  logic                 pix_valid;
  ckpm_pixel_t          pix;
  logic                 res_valid;
  ckpm_result_t         res;
  ckpm_result_t         res_next;
  logic                 res_adv;
  logic                 in_ready;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 cfg_we;

  function automatic logic [ChanW-1:0] abs_gap(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    abs_gap = (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_red         <= KEY_RED_RST;
      key_green       <= KEY_GREEN_RST;
      key_blue        <= KEY_BLUE_RST;
      distance_mode   <= DIST_MODE_RST;
      match_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_KEY_RED:      key_red         <= pwdata[ChanW-1:0];
        REG_KEY_GREEN:    key_green       <= pwdata[ChanW-1:0];
        REG_KEY_BLUE:     key_blue        <= pwdata[ChanW-1:0];
        REG_DIST_MODE:    distance_mode   <= pwdata[ModeW-1:0];
        REG_MATCH_THRESH: match_threshold <= pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_RED:      prdata = {{(ApbDataW-ChanW){1'b0}}, key_red};
      REG_KEY_GREEN:    prdata = {{(ApbDataW-ChanW){1'b0}}, key_green};
      REG_KEY_BLUE:     prdata = {{(ApbDataW-ChanW){1'b0}}, key_blue};
      REG_DIST_MODE:    prdata = {{(ApbDataW-ModeW){1'b0}}, distance_mode};
      REG_MATCH_THRESH: prdata = {{(ApbDataW-DistW){1'b0}}, match_threshold};
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  assign res_adv      = !res_valid || result.ready;
  assign in_ready     = !pix_valid || res_adv;
  assign pixel.ready  = in_ready;
  assign result.valid = res_valid;
  assign result.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ready) pix_valid <= pixel.valid;
      if (res_adv)  res_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && pixel.valid) pix <= pixel.data;
    if (res_adv && pix_valid)    res <= res_next;
  end

  // distance and composite
  always_comb begin
    logic [ChanW-1:0]   dr, dg, db, dmax;
    logic [2*ChanW-1:0] sr, sg, sb;
    logic [DistW-1:0]   distance;
    logic               hit;

    dr   = abs_gap(pix.fg_red,   key_red);
    dg   = abs_gap(pix.fg_green, key_green);
    db   = abs_gap(pix.fg_blue,  key_blue);
    sr   = dr * dr;
    sg   = dg * dg;
    sb   = db * db;
    dmax = (dr > dg) ? dr : dg;
    dmax = (dmax > db) ? dmax : db;

    unique case (distance_mode)
      MODE_SAD: distance = DistW'(dr) + DistW'(dg) + DistW'(db);
      MODE_SSD: distance = DistW'(sr) + DistW'(sg) + DistW'(sb);
      MODE_MAX: distance = DistW'(dmax);
      default:  distance = '0;
    endcase

    hit = distance <= match_threshold;

    res_next.key_match      = hit;
    res_next.color_distance = distance;
    res_next.out_red        = hit ? pix.bg_red   : pix.fg_red;
    res_next.out_green      = hit ? pix.bg_green : pix.fg_green;
    res_next.out_blue       = hit ? pix.bg_blue  : pix.fg_blue;
    res_next.alpha_new      = hit ? ALPHA_CLEAR  : ALPHA_OPAQUE;
    res_next.alpha_updated  = hit ? ALPHA_CLEAR  : pix.alpha_in;
  end

endmodule

// ===== rtl/core/ckpm_checker.sv =====
module ckpm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          key_match,
  input logic [ckpm_pkg::ChanW-1:0]    alpha_new,
  input logic [ckpm_pkg::ChanW-1:0]    alpha_updated
);
  import ckpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_keyed_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_match |-> alpha_new == ALPHA_CLEAR && alpha_updated == ALPHA_CLEAR)
    else $error("keyed pixel with nonzero alpha");

  a_open_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_match |-> alpha_new == ALPHA_OPAQUE)
    else $error("unkeyed pixel without opaque alpha");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

bind chroma_key_pixel_matcher ckpm_checker u_ckpm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pixel.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .key_match     (result.data.key_match),
  .alpha_new     (result.data.alpha_new),
  .alpha_updated (result.data.alpha_updated)
);

// ===== test/chroma_key_pixel_matcher_checker.sv =====
module chroma_key_pixel_matcher_checker (
  input  logic                          clk,
  input  logic                          rst,
  ckpm_pixel_if                         pixel,
  ckpm_result_if                        result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [ckpm_pkg::ApbAddrW-1:0] paddr,
  input  logic [ckpm_pkg::ApbDataW-1:0] pwdata,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ckpm_pkg::ChanW-1:0] key_r;
  logic [ckpm_pkg::ChanW-1:0] key_g;
  logic [ckpm_pkg::ChanW-1:0] key_b;
  logic [ckpm_pkg::ModeW-1:0] dist_mode;
  logic [ckpm_pkg::DistW-1:0] key_thresh;

  ckpm_pkg::ckpm_result_t composite_q[$];
  int fails = 0;
  int depth = 0;

  assign fail_count = fails;
  assign pending    = depth;

  function automatic logic [7:0] chan_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic ckpm_pkg::ckpm_result_t keyed_result(input ckpm_pkg::ckpm_pixel_t px);
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [7:0] peak;
    logic [17:0] distance;
    logic hit;
    ckpm_pkg::ckpm_result_t res;
    dr = chan_gap(px.fg_red, key_r);
    dg = chan_gap(px.fg_green, key_g);
    db = chan_gap(px.fg_blue, key_b);
    case (dist_mode)
      ckpm_pkg::MODE_SAD: begin
        distance = {10'd0, dr} + {10'd0, dg} + {10'd0, db};
      end
      ckpm_pkg::MODE_SSD: begin
        distance = {10'd0, dr} * {10'd0, dr} + {10'd0, dg} * {10'd0, dg}
                 + {10'd0, db} * {10'd0, db};
      end
      ckpm_pkg::MODE_MAX: begin
        peak = (dr > dg) ? dr : dg;
        peak = (peak > db) ? peak : db;
        distance = {10'd0, peak};
      end
      default: begin
        distance = '0;
      end
    endcase
    hit = (distance <= key_thresh);
    res.key_match      = hit;
    res.color_distance = distance;
    res.out_red        = hit ? px.bg_red   : px.fg_red;
    res.out_green      = hit ? px.bg_green : px.fg_green;
    res.out_blue       = hit ? px.bg_blue  : px.fg_blue;
    res.alpha_new      = hit ? ckpm_pkg::ALPHA_CLEAR : ckpm_pkg::ALPHA_OPAQUE;
    res.alpha_updated  = hit ? ckpm_pkg::ALPHA_CLEAR : px.alpha_in;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    ckpm_pkg::ckpm_result_t want;
    if (rst) begin
      composite_q.delete();
      key_r      = ckpm_pkg::KEY_RED_RST;
      key_g      = ckpm_pkg::KEY_GREEN_RST;
      key_b      = ckpm_pkg::KEY_BLUE_RST;
      dist_mode  = ckpm_pkg::DIST_MODE_RST;
      key_thresh = ckpm_pkg::THRESH_RST;
    end else begin
      if (result.valid && result.ready) begin
        if (composite_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = composite_q.pop_front();
          check_field("key_match", 32'(want.key_match),
                      32'(result.data.key_match));
          check_field("color_distance", 32'(want.color_distance),
                      32'(result.data.color_distance));
          check_field("out_red", 32'(want.out_red), 32'(result.data.out_red));
          check_field("out_green", 32'(want.out_green), 32'(result.data.out_green));
          check_field("out_blue", 32'(want.out_blue), 32'(result.data.out_blue));
          check_field("alpha_new", 32'(want.alpha_new), 32'(result.data.alpha_new));
          check_field("alpha_updated", 32'(want.alpha_updated),
                      32'(result.data.alpha_updated));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          ckpm_pkg::REG_KEY_RED:      key_r      = pwdata[7:0];
          ckpm_pkg::REG_KEY_GREEN:    key_g      = pwdata[7:0];
          ckpm_pkg::REG_KEY_BLUE:     key_b      = pwdata[7:0];
          ckpm_pkg::REG_DIST_MODE:    dist_mode  = pwdata[1:0];
          ckpm_pkg::REG_MATCH_THRESH: key_thresh = pwdata[17:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready) begin
        composite_q.push_back(keyed_result(pixel.data));
      end
    end
    depth = composite_q.size();
  end

endmodule

// ===== test/chroma_key_pixel_matcher_tb.sv =====
module chroma_key_pixel_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 300000;
  localparam int LongHoldAt  = 300;
  localparam int LongHoldLen = 250;
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 115;
  localparam logic [ckpm_pkg::ModeW-1:0] ModeUnused = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic pready;
  logic [ckpm_pkg::ApbAddrW-1:0] paddr;
  logic [ckpm_pkg::ApbDataW-1:0] pwdata;
  logic [ckpm_pkg::ApbDataW-1:0] prdata;
  int fail_count;
  int pending;
  int cycle_count = 0;

  ckpm_pixel_if  pix_ch ();
  ckpm_result_if res_ch ();

  chroma_key_pixel_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  chroma_key_pixel_matcher_checker match_check (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pix_ch),
    .result     (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[chroma_key_pixel_matcher] ERROR");
      $finish;
    end
  end

  function automatic ckpm_pkg::ckpm_pixel_t make_px(input int f_r, input int f_g,
                                                    input int f_b, input int b_r,
                                                    input int b_g, input int b_b,
                                                    input int alp);
    ckpm_pkg::ckpm_pixel_t px;
    px.fg_red   = 8'(f_r);
    px.fg_green = 8'(f_g);
    px.fg_blue  = 8'(f_b);
    px.bg_red   = 8'(b_r);
    px.bg_green = 8'(b_g);
    px.bg_blue  = 8'(b_b);
    px.alpha_in = 8'(alp);
    return px;
  endfunction

  function automatic int chan_near(input int k, input bit close);
    int v;
    if (!close) begin
      return $urandom_range(0, 255);
    end
    v = k + $urandom_range(0, 24) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic int pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_gap(input bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic reg_write(input logic [ckpm_pkg::RegIdxW-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_keying(input int kr, input int kg, input int kb,
                            input logic [ckpm_pkg::ModeW-1:0] mode, input int thr);
    drain();
    reg_write(ckpm_pkg::REG_KEY_RED, kr);
    reg_write(ckpm_pkg::REG_KEY_GREEN, kg);
    reg_write(ckpm_pkg::REG_KEY_BLUE, kb);
    reg_write(ckpm_pkg::REG_DIST_MODE, {30'd0, mode});
    reg_write(ckpm_pkg::REG_MATCH_THRESH, thr);
  endtask

  // called on a rising-edge step; leaves valid high after the request is taken
  task automatic send_pixel(input ckpm_pkg::ckpm_pixel_t px, input bit no_gaps);
    int gap;
    gap = pick_gap(no_gaps);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= px;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  initial begin : result_sink
    int hold_left;
    int style_left;
    int style;
    int n_res;
    bit long_done;
    hold_left  = 0;
    style_left = 0;
    style      = 0;
    n_res      = 0;
    long_done  = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) n_res++;
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(20, 80);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!long_done && n_res >= LongHoldAt) begin
        long_done = 1'b1;
        hold_left = LongHoldLen - 1;
        res_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 3) != 0);
          2: res_ch.ready <= ($urandom_range(0, 1) == 1);
          default: begin
            if ($urandom_range(0, 24) == 0) begin
              hold_left = $urandom_range(10, 40);
              res_ch.ready <= 1'b0;
            end else begin
              res_ch.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    ckpm_pkg::ckpm_pixel_t px;
    int kr;
    int kg;
    int kb;
    int thr;
    int scale;
    int r;
    bit close;
    bit no_gaps;
    logic [ckpm_pkg::ModeW-1:0] mode;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: key (0,0,255), abs sum, threshold 10
    send_pixel(make_px(0, 0, 255, 8'haa, 8'h55, 8'hff, 8'h5a), 1'b0);
    send_pixel(make_px(5, 5, 255, 1, 2, 3, 200), 1'b0);
    send_pixel(make_px(5, 6, 255, 1, 2, 3, 200), 1'b0);
    send_pixel(make_px(0, 0, 0, 255, 255, 255, 255), 1'b0);
    send_pixel(make_px(255, 255, 255, 0, 0, 0, 0), 1'b0);
    send_pixel(make_px(255, 255, 0, 8'h55, 8'h55, 8'h55, 8'h55), 1'b0);
    send_pixel(make_px(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa), 1'b0);
    pix_ch.valid <= 1'b0;

    set_keying(0, 0, 0, ckpm_pkg::MODE_SSD, 195075);
    send_pixel(make_px(255, 255, 255, 8'haa, 8'haa, 8'haa, 77), 1'b0);
    send_pixel(make_px(0, 0, 0, 8'h55, 8'h55, 8'h55, 77), 1'b0);
    pix_ch.valid <= 1'b0;

    set_keying(0, 0, 0, ckpm_pkg::MODE_SSD, 195074);
    send_pixel(make_px(255, 255, 255, 9, 8, 7, 6), 1'b0);
    send_pixel(make_px(255, 255, 254, 9, 8, 7, 6), 1'b0);
    pix_ch.valid <= 1'b0;

    set_keying(128, 128, 128, ckpm_pkg::MODE_MAX, 127);
    send_pixel(make_px(0, 128, 128, 10, 20, 30, 40), 1'b0);
    send_pixel(make_px(255, 128, 128, 10, 20, 30, 40), 1'b0);
    send_pixel(make_px(128, 1, 255, 10, 20, 30, 40), 1'b0);
    pix_ch.valid <= 1'b0;

    set_keying(255, 255, 255, ckpm_pkg::MODE_MAX, 0);
    send_pixel(make_px(255, 255, 255, 1, 1, 1, 1), 1'b0);
    send_pixel(make_px(255, 255, 254, 1, 1, 1, 1), 1'b0);
    pix_ch.valid <= 1'b0;

    // unused mode: distance reads zero, always keyed
    set_keying(8'h55, 8'haa, 8'h0f, ModeUnused, 0);
    send_pixel(make_px(0, 255, 0, 3, 4, 5, 6), 1'b0);
    send_pixel(make_px(255, 0, 255, 3, 4, 5, 6), 1'b0);
    pix_ch.valid <= 1'b0;

    // threshold above any reachable distance
    set_keying(0, 0, 255, ckpm_pkg::MODE_SAD, 262143);
    send_pixel(make_px(255, 255, 0, 12, 34, 56, 78), 1'b0);
    pix_ch.valid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      r = $urandom_range(0, 99);
      if (r < 30) mode = ckpm_pkg::MODE_SAD;
      else if (r < 60) mode = ckpm_pkg::MODE_SSD;
      else if (r < 92) mode = ckpm_pkg::MODE_MAX;
      else mode = ModeUnused;
      case (mode)
        ckpm_pkg::MODE_SAD: scale = 765;
        ckpm_pkg::MODE_SSD: scale = 195075;
        default:            scale = 255;
      endcase
      r = $urandom_range(0, 99);
      if (r < 10) thr = 0;
      else if (r < 20) thr = scale;
      else if (r < 25) thr = $urandom_range(scale + 1, 262143);
      else if (mode == ckpm_pkg::MODE_SSD) thr = $urandom_range(0, scale / 16);
      else thr = $urandom_range(0, scale / 3);
      kr = pick_key();
      kg = pick_key();
      kb = pick_key();
      set_keying(kr, kg, kb, mode, thr);
      no_gaps = (ph % 4 == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        close = ($urandom_range(0, 1) == 1);
        px = make_px(chan_near(kr, close), chan_near(kg, close), chan_near(kb, close),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
        send_pixel(px, no_gaps);
      end
      pix_ch.valid <= 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[chroma_key_pixel_matcher] OK");
    end else begin
      $display("[chroma_key_pixel_matcher] ERROR");
    end
    $finish;
  end

endmodule

// ===== chroma_key_pixel_matcher.f =====
rtl/core/ckpm_pkg.sv
rtl/core/ckpm_if.sv
rtl/core/chroma_key_pixel_matcher.sv
rtl/core/ckpm_checker.sv
test/chroma_key_pixel_matcher_checker.sv
test/chroma_key_pixel_matcher_tb.sv
